/* src/tfp_pkg.sv */
// ----------------------------------------------------------------------------
// tfp_pkg
// Types and constants shared by the tilt filter / drive law / PWM block.
// ----------------------------------------------------------------------------
package tfp_pkg;

  localparam int TiltW = 40;
  localparam int DiffW = 41;
  localparam int AccW  = 60;
  localparam int MulAW = 17;
  localparam int MulBW = 25;
  localparam int ProdW = MulAW + MulBW;
  localparam int LoW   = 24;
  localparam int DrvW  = 13;

  // Q0.16 filter constants
  localparam logic signed [MulAW-1:0] FiltKeep  = 17'sd64881;
  localparam logic signed [MulBW-1:0] GyroStep  = 25'sd1638;
  localparam logic signed [MulBW-1:0] AccelMixN = -25'sd9175;
  localparam logic signed [AccW-1:0]  RoundHalf = 60'sd32768;

  localparam logic signed [TiltW-1:0] TiltMax = {1'b0, {(TiltW-1){1'b1}}};
  localparam logic signed [TiltW-1:0] TiltMin = {1'b1, {(TiltW-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_GAIN_PROP   = 3'd0,
    REG_GAIN_DERIV  = 3'd1,
    REG_GAIN_SPEED  = 3'd2,
    REG_GAIN_BOOST  = 3'd3,
    REG_BOOST_THR   = 3'd4,
    REG_DRIVE_LIMIT = 3'd5,
    REG_DEADBAND    = 3'd6,
    REG_TILT_OFFSET = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] gain_prop;
    logic signed [15:0] gain_deriv;
    logic signed [15:0] gain_speed;
    logic signed [15:0] gain_boost;
    logic [14:0]        boost_threshold;
    logic [11:0]        drive_limit;
    logic [11:0]        deadband_offset;
    logic signed [15:0] tilt_offset;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_FILT_S,
    OP_FILT_LO,
    OP_FILT_HI,
    OP_MIX,
    OP_SAT,
    OP_DERIV,
    OP_WHEEL,
    OP_PROP_LO,
    OP_PROP_HI,
    OP_BOOST_LO,
    OP_BOOST_HI,
    OP_TRUNC,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILT_S,
    ST_FILT_LO,
    ST_FILT_HI,
    ST_MIX,
    ST_SAT,
    ST_DERIV,
    ST_WHEEL,
    ST_PROP_LO,
    ST_PROP_HI,
    ST_BOOST_LO,
    ST_BOOST_HI,
    ST_TRUNC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_in;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
  } status_t;

endpackage

/* src/tilt_filter_pid_pwm_boosted_unit.sv */
// ----------------------------------------------------------------------------
// tilt_filter_pid_pwm_boosted_unit
// Complementary tilt filter, boosted PD drive law and sign-magnitude PWM out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | slave     | in_tvalid/tready   | accel_tilt, gyro_rate, wheel_speed
//  out_    | master    | out_tvalid/tready  | duty, reverse
//  cfg_    | slave     | cfg_valid/ready    | cfg_index, cfg_data
//
//  Per item: an idle/accept state, twelve datapath steps around the shared
//  17x25 multiply-accumulate (filter, mix, saturate, drive terms,
//  truncate/clamp) and an emit state that loads the output register.
//  A held result stalls the final load, and no new item is accepted until it goes.
//  rst_n (synchronous) clears tilt state, sequencer and output valid; loads cfg defaults.
// ----------------------------------------------------------------------------
module tilt_filter_pid_pwm_boosted_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // accel_tilt[15:0], gyro_rate[31:16], wheel_speed[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // duty[12:0], reverse[13], zero[15:14]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  tfp_pkg::cfg_t    cfg;
  tfp_pkg::cmd_t    cmd;
  tfp_pkg::status_t status;

  tfp_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tfp_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .cfg        (cfg),
    .in_data    (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (out_tdata)
  );

endmodule

/* src/tfp_regs.sv */
// ----------------------------------------------------------------------------
// tfp_regs
// Configuration register bank with write channel.
// ----------------------------------------------------------------------------
module tfp_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  output tfp_pkg::cfg_t    cfg
);

  tfp_pkg::cfg_t cfg_r;
  tfp_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (tfp_pkg::reg_idx_t'(cfg_index))
        tfp_pkg::REG_GAIN_PROP:   cfg_nxt.gain_prop       = cfg_data;
        tfp_pkg::REG_GAIN_DERIV:  cfg_nxt.gain_deriv      = cfg_data;
        tfp_pkg::REG_GAIN_SPEED:  cfg_nxt.gain_speed      = cfg_data;
        tfp_pkg::REG_GAIN_BOOST:  cfg_nxt.gain_boost      = cfg_data;
        tfp_pkg::REG_BOOST_THR:   cfg_nxt.boost_threshold = cfg_data[14:0];
        tfp_pkg::REG_DRIVE_LIMIT: cfg_nxt.drive_limit     = cfg_data[11:0];
        tfp_pkg::REG_DEADBAND:    cfg_nxt.deadband_offset = cfg_data[11:0];
        tfp_pkg::REG_TILT_OFFSET: cfg_nxt.tilt_offset     = cfg_data;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_prop       <= 16'sd218;
      cfg_r.gain_deriv      <= 16'sd87;
      cfg_r.gain_speed      <= -16'sd2816;
      cfg_r.gain_boost      <= 16'sd461;
      cfg_r.boost_threshold <= 15'd250;
      cfg_r.drive_limit     <= 12'd2900;
      cfg_r.deadband_offset <= 12'd700;
      cfg_r.tilt_offset     <= 16'sd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* src/tfp_ctrl.sv */
// ----------------------------------------------------------------------------
// tfp_ctrl
// Sequencer: steps the shared multiply-accumulate through one sample.
// ----------------------------------------------------------------------------
module tfp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  tfp_pkg::status_t  status,
  output tfp_pkg::cmd_t     cmd
);

  tfp_pkg::state_t state_r;
  tfp_pkg::state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tfp_pkg::ST_IDLE:     if (in_tvalid) state_nxt = tfp_pkg::ST_FILT_S;
      tfp_pkg::ST_FILT_S:   state_nxt = tfp_pkg::ST_FILT_LO;
      tfp_pkg::ST_FILT_LO:  state_nxt = tfp_pkg::ST_FILT_HI;
      tfp_pkg::ST_FILT_HI:  state_nxt = tfp_pkg::ST_MIX;
      tfp_pkg::ST_MIX:      state_nxt = tfp_pkg::ST_SAT;
      tfp_pkg::ST_SAT:      state_nxt = tfp_pkg::ST_DERIV;
      tfp_pkg::ST_DERIV:    state_nxt = tfp_pkg::ST_WHEEL;
      tfp_pkg::ST_WHEEL:    state_nxt = tfp_pkg::ST_PROP_LO;
      tfp_pkg::ST_PROP_LO:  state_nxt = tfp_pkg::ST_PROP_HI;
      tfp_pkg::ST_PROP_HI:  state_nxt = tfp_pkg::ST_BOOST_LO;
      tfp_pkg::ST_BOOST_LO: state_nxt = tfp_pkg::ST_BOOST_HI;
      tfp_pkg::ST_BOOST_HI: state_nxt = tfp_pkg::ST_TRUNC;
      tfp_pkg::ST_TRUNC:    state_nxt = tfp_pkg::ST_EMIT;
      tfp_pkg::ST_EMIT:     if (status.slot_free) state_nxt = tfp_pkg::ST_IDLE;
      default:              state_nxt = tfp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd.load_in = 1'b0;
    cmd.op      = tfp_pkg::OP_NONE;
    unique case (state_r)
      tfp_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      tfp_pkg::ST_FILT_S:   cmd.op = tfp_pkg::OP_FILT_S;
      tfp_pkg::ST_FILT_LO:  cmd.op = tfp_pkg::OP_FILT_LO;
      tfp_pkg::ST_FILT_HI:  cmd.op = tfp_pkg::OP_FILT_HI;
      tfp_pkg::ST_MIX:      cmd.op = tfp_pkg::OP_MIX;
      tfp_pkg::ST_SAT:      cmd.op = tfp_pkg::OP_SAT;
      tfp_pkg::ST_DERIV:    cmd.op = tfp_pkg::OP_DERIV;
      tfp_pkg::ST_WHEEL:    cmd.op = tfp_pkg::OP_WHEEL;
      tfp_pkg::ST_PROP_LO:  cmd.op = tfp_pkg::OP_PROP_LO;
      tfp_pkg::ST_PROP_HI:  cmd.op = tfp_pkg::OP_PROP_HI;
      tfp_pkg::ST_BOOST_LO: cmd.op = tfp_pkg::OP_BOOST_LO;
      tfp_pkg::ST_BOOST_HI: cmd.op = tfp_pkg::OP_BOOST_HI;
      tfp_pkg::ST_TRUNC:    cmd.op = tfp_pkg::OP_TRUNC;
      tfp_pkg::ST_EMIT: begin
        if (status.slot_free) cmd.op = tfp_pkg::OP_EMIT;
      end
      default: cmd.op = tfp_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tfp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* src/tfp_dpath.sv */
// ----------------------------------------------------------------------------
// tfp_dpath
// Datapath: sample registers, filter state, shared 17x25 multiply-accumulate,
// truncate/clamp and the output register.
// ----------------------------------------------------------------------------
module tfp_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  tfp_pkg::cmd_t     cmd,
  output tfp_pkg::status_t  status,
  input  tfp_pkg::cfg_t     cfg,
  input  logic [47:0]       in_data,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_data
);

  logic signed [15:0]                accel_r, gyro_r, wheel_r;
  logic signed [tfp_pkg::TiltW-1:0]  tilt_r, tilt_nxt;
  logic signed [16:0]                s_hi_r, s_hi_nxt;
  logic signed [tfp_pkg::DiffW-1:0]  err_r, err_nxt;
  logic signed [tfp_pkg::DiffW-1:0]  bst_r, bst_nxt;
  logic signed [tfp_pkg::AccW-1:0]   acc_r, acc_nxt;
  logic signed [tfp_pkg::DrvW-1:0]   drv_r, drv_nxt;
  logic [12:0]                       duty_r, duty_nxt;
  logic                              rev_r, rev_nxt;
  logic                              out_valid_r, out_valid_nxt;

  logic signed [tfp_pkg::MulAW-1:0]  mul_a;
  logic signed [tfp_pkg::MulBW-1:0]  mul_b;
  logic signed [tfp_pkg::ProdW-1:0]  prod;
  logic signed [tfp_pkg::AccW-1:0]   prod_ext;
  logic signed [tfp_pkg::AccW-1:0]   addend;
  logic signed [tfp_pkg::AccW-1:0]   base;
  logic                              acc_en;
  logic [1:0]                        sh_sel;

  logic signed [tfp_pkg::DiffW-1:0]  tilt_ext, thr;
  logic signed [tfp_pkg::AccW-1:0]   rnd;
  logic signed [35:0]                quo, lim;
  logic [11:0]                       mag;

  assign prod     = mul_a * mul_b;
  assign prod_ext = tfp_pkg::AccW'(prod);

  always_comb begin
    case (sh_sel)
      2'd1:    addend = prod_ext <<< 16;
      2'd2:    addend = prod_ext <<< 24;
      default: addend = prod_ext;
    endcase
  end

  assign tilt_ext = tfp_pkg::DiffW'(tilt_r);
  assign thr      = signed'({10'b0, cfg.boost_threshold, 16'b0});
  assign rnd      = acc_r + tfp_pkg::AccW'({24{acc_r[tfp_pkg::AccW-1]}});
  assign quo      = 36'(rnd >>> 24);
  assign lim      = signed'({24'b0, cfg.drive_limit});
  assign mag      = drv_r[tfp_pkg::DrvW-1] ? 12'(-drv_r) : 12'(drv_r);

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    base     = acc_r;
    sh_sel   = 2'd0;
    acc_en   = 1'b0;
    tilt_nxt = tilt_r;
    s_hi_nxt = s_hi_r;
    err_nxt  = err_r;
    bst_nxt  = bst_r;
    drv_nxt  = drv_r;
    duty_nxt = duty_r;
    rev_nxt  = rev_r;
    unique case (cmd.op)
      tfp_pkg::OP_FILT_S: begin
        mul_a  = 17'(gyro_r);
        mul_b  = tfp_pkg::GyroStep;
        base   = tfp_pkg::AccW'(tilt_r);
        acc_en = 1'b1;
      end
      tfp_pkg::OP_FILT_LO: begin
        mul_a    = tfp_pkg::FiltKeep;
        mul_b    = signed'({1'b0, acc_r[tfp_pkg::LoW-1:0]});
        base     = tfp_pkg::RoundHalf;
        s_hi_nxt = acc_r[40:24];
        acc_en   = 1'b1;
      end
      tfp_pkg::OP_FILT_HI: begin
        mul_a  = tfp_pkg::FiltKeep;
        mul_b  = 25'(s_hi_r);
        sh_sel = 2'd2;
        acc_en = 1'b1;
      end
      tfp_pkg::OP_MIX: begin
        mul_a  = 17'(accel_r);
        mul_b  = tfp_pkg::AccelMixN;
        base   = acc_r >>> 16;
        acc_en = 1'b1;
      end
      tfp_pkg::OP_SAT: begin
        if ((&acc_r[59:39]) || !(|acc_r[59:39])) begin
          tilt_nxt = acc_r[39:0];
        end else if (acc_r[59]) begin
          tilt_nxt = tfp_pkg::TiltMin;
        end else begin
          tilt_nxt = tfp_pkg::TiltMax;
        end
      end
      tfp_pkg::OP_DERIV: begin
        mul_a   = 17'(cfg.gain_deriv);
        mul_b   = 25'(gyro_r);
        base    = '0;
        sh_sel  = 2'd1;
        acc_en  = 1'b1;
        err_nxt = tilt_ext - (tfp_pkg::DiffW'(cfg.tilt_offset) <<< 16);
        if (tilt_ext > thr) begin
          bst_nxt = tilt_ext - thr;
        end else if (tilt_ext < -thr) begin
          bst_nxt = tilt_ext + thr;
        end else begin
          bst_nxt = '0;
        end
      end
      tfp_pkg::OP_WHEEL: begin
        mul_a  = 17'(cfg.gain_speed);
        mul_b  = 25'(wheel_r);
        sh_sel = 2'd1;
        acc_en = 1'b1;
      end
      tfp_pkg::OP_PROP_LO: begin
        mul_a  = 17'(cfg.gain_prop);
        mul_b  = signed'({1'b0, err_r[tfp_pkg::LoW-1:0]});
        acc_en = 1'b1;
      end
      tfp_pkg::OP_PROP_HI: begin
        mul_a  = 17'(cfg.gain_prop);
        mul_b  = 25'($signed(err_r[40:24]));
        sh_sel = 2'd2;
        acc_en = 1'b1;
      end
      tfp_pkg::OP_BOOST_LO: begin
        mul_a  = 17'(cfg.gain_boost);
        mul_b  = signed'({1'b0, bst_r[tfp_pkg::LoW-1:0]});
        acc_en = 1'b1;
      end
      tfp_pkg::OP_BOOST_HI: begin
        mul_a  = 17'(cfg.gain_boost);
        mul_b  = 25'($signed(bst_r[40:24]));
        sh_sel = 2'd2;
        acc_en = 1'b1;
      end
      tfp_pkg::OP_TRUNC: begin
        if (quo > lim) begin
          drv_nxt = 13'(lim);
        end else if (quo < -lim) begin
          drv_nxt = 13'(-lim);
        end else begin
          drv_nxt = 13'(quo);
        end
      end
      tfp_pkg::OP_EMIT: begin
        duty_nxt = {1'b0, mag} + {1'b0, cfg.deadband_offset};
        rev_nxt  = drv_r[tfp_pkg::DrvW-1];
      end
      default: begin
        acc_en = 1'b0;
      end
    endcase
    acc_nxt = acc_en ? (base + addend) : acc_r;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (cmd.op == tfp_pkg::OP_EMIT) out_valid_nxt = 1'b1;
  end

  assign status.slot_free = !out_valid_r || out_tready;
  assign out_tvalid       = out_valid_r;
  assign out_data         = {2'b0, rev_r, duty_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tilt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tilt_r      <= tilt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      accel_r <= in_data[15:0];
      gyro_r  <= in_data[31:16];
      wheel_r <= in_data[47:32];
    end
    s_hi_r <= s_hi_nxt;
    err_r  <= err_nxt;
    bst_r  <= bst_nxt;
    acc_r  <= acc_nxt;
    drv_r  <= drv_nxt;
    duty_r <= duty_nxt;
    rev_r  <= rev_nxt;
  end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives tilt, gyro and wheel samples into the tilt filter / drive law unit,
// predicts each PWM item (filter state, boosted drive sum, truncation, clamp)
// and checks duty and direction as they leave, under varied register settings
// and random stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint KeepQ16    = 64881;
  localparam longint GyroQ16    = 1638;
  localparam longint MixQ16     = 9175;
  localparam longint OneQ16     = 65536;
  localparam longint TiltHi     = (longint'(1) <<< 39) - 1;
  localparam longint TiltLo     = -(longint'(1) <<< 39);
  localparam int     IdleGap    = 20;
  localparam int     HoldCycles = 400;
  localparam int     CycleLimit = 400000;

  typedef struct packed {
    logic [12:0] duty;
    logic        rev;
  } pwm_t;

  typedef struct packed {
    logic signed [15:0] accel;
    logic signed [15:0] gyro;
    logic signed [15:0] wheel;
    logic               typed;
    pwm_t               want;
  } probe_t;

  localparam probe_t Probes [13] = '{
    '{16'sd0,     16'sd0,     16'sd0,     1'b1, '{13'd700,  1'b0}},
    '{16'sh8000,  16'sd0,     16'sd0,     1'b1, '{13'd3600, 1'b0}},
    '{16'sd0,     16'sd0,     16'sh7FFF,  1'b1, '{13'd3600, 1'b1}},
    '{16'sh7FFF,  16'sd0,     16'sd0,     1'b0, '0},
    '{16'sd0,     16'sh7FFF,  16'sd0,     1'b0, '0},
    '{16'sd0,     16'sh8000,  16'sd0,     1'b0, '0},
    '{16'sd0,     16'sd0,     16'sh8000,  1'b0, '0},
    '{16'sh8000,  16'sh7FFF,  16'sh8000,  1'b0, '0},
    '{16'sh7FFF,  16'sh8000,  16'sh7FFF,  1'b0, '0},
    '{16'shFFFF,  16'shFFFF,  16'shFFFF,  1'b0, '0},
    '{16'sd1,     16'sd1,     16'sd1,     1'b0, '0},
    '{16'sd0,     16'sd0,     16'sd0,     1'b0, '0},
    '{16'sd0,     16'sd0,     16'sd0,     1'b0, '0}
  };

  localparam tfp_pkg::cfg_t Presets [4] = '{
    '{16'sd218, 16'sd87, -16'sd2816, 16'sd461, 15'd250, 12'd2900, 12'd700, 16'sd0},
    '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 15'h7FFF, 12'hFFF, 12'hFFF, 16'sh7FFF},
    '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 15'd0, 12'd0, 12'd0, 16'sh8000},
    '{16'sh7FFF, 16'sh8000, 16'sd0, 16'sh8000, 15'd0, 12'hFFF, 12'd0, 16'sh8000}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // accel_tilt[15:0], gyro_rate[31:16], wheel_speed[47:32]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // duty[12:0], reverse[13], zero[15:14]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  tfp_pkg::cfg_t drive_regs;
  longint        tilt_q16;
  pwm_t          pending_pwm [$];
  int            errors = 0;
  int            src_idle_pct = 0;
  int            sink_stall_pct = 0;
  logic          sink_hold = 1'b0;
  int unsigned   cycles = 0;

  tilt_filter_pid_pwm_boosted_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // one filter step and drive law; advances the tilt estimate
  function automatic pwm_t predict_drive(input logic signed [15:0] accel,
                                         input logic signed [15:0] gyro,
                                         input logic signed [15:0] wheel);
    longint s, r, t, thr, sum, drv, lim, mag;
    pwm_t   res;
    s = tilt_q16 + longint'(gyro) * GyroQ16;
    r = (s * KeepQ16 + 32768) >>> 16;
    t = r - longint'(accel) * MixQ16;
    if (t > TiltHi) t = TiltHi;
    if (t < TiltLo) t = TiltLo;
    tilt_q16 = t;
    sum = longint'(drive_regs.gain_deriv) * longint'(gyro) * OneQ16
        + longint'(drive_regs.gain_prop) * (t - longint'(drive_regs.tilt_offset) * OneQ16)
        + longint'(drive_regs.gain_speed) * longint'(wheel) * OneQ16;
    thr = longint'(drive_regs.boost_threshold) * OneQ16;
    if (t > thr) sum = sum + longint'(drive_regs.gain_boost) * (t - thr);
    else if (t < -thr) sum = sum + longint'(drive_regs.gain_boost) * (t + thr);
    drv = (sum < 0) ? -((-sum) >>> 24) : (sum >>> 24);
    lim = longint'(drive_regs.drive_limit);
    if (drv > lim) drv = lim;
    if (drv < -lim) drv = -lim;
    mag = (drv < 0) ? -drv : drv;
    res.duty = 13'(mag + longint'(drive_regs.deadband_offset));
    res.rev  = (drv < 0);
    return res;
  endfunction

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(600) - 300);
      2: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'shFFFF;
          default: return 16'sd0;
        endcase
      end
      default: return 16'($urandom_range(4000) - 2000);
    endcase
  endfunction

  function automatic tfp_pkg::cfg_t pick_settings();
    tfp_pkg::cfg_t s;
    s.gain_prop   = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(1023) - 512);
    s.gain_deriv  = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(1023) - 512);
    s.gain_speed  = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(1023) - 512);
    s.gain_boost  = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(1023) - 512);
    s.boost_threshold = $urandom_range(1) ? 15'($urandom) : 15'($urandom_range(600));
    s.drive_limit     = 12'($urandom);
    s.deadband_offset = 12'($urandom);
    s.tilt_offset = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(200) - 100);
    return s;
  endfunction

  // leaves in_tvalid high after the handshake
  task automatic send_item(input logic signed [15:0] accel, input logic signed [15:0] gyro,
                           input logic signed [15:0] wheel, input logic typed,
                           input pwm_t want);
    pwm_t calc;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {wheel, gyro, accel};
    do @(posedge clk); while (!in_tready);
    calc = predict_drive(accel, gyro, wheel);
    pending_pwm.push_back(typed ? want : calc);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_item(pick_sample(), pick_sample(), pick_sample(), 1'b0, '0);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_pwm.size() != 0) @(posedge clk);
    repeat (IdleGap) @(posedge clk);
  endtask

  // leaves cfg_valid high after the handshake
  task automatic cfg_write(input tfp_pkg::reg_idx_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tfp_pkg::REG_GAIN_PROP:   drive_regs.gain_prop = val;
      tfp_pkg::REG_GAIN_DERIV:  drive_regs.gain_deriv = val;
      tfp_pkg::REG_GAIN_SPEED:  drive_regs.gain_speed = val;
      tfp_pkg::REG_GAIN_BOOST:  drive_regs.gain_boost = val;
      tfp_pkg::REG_BOOST_THR:   drive_regs.boost_threshold = val[14:0];
      tfp_pkg::REG_DRIVE_LIMIT: drive_regs.drive_limit = val[11:0];
      tfp_pkg::REG_DEADBAND:    drive_regs.deadband_offset = val[11:0];
      tfp_pkg::REG_TILT_OFFSET: drive_regs.tilt_offset = val;
    endcase
  endtask

  task automatic apply_settings(input tfp_pkg::cfg_t s);
    cfg_write(tfp_pkg::REG_GAIN_PROP, s.gain_prop);
    cfg_write(tfp_pkg::REG_GAIN_DERIV, s.gain_deriv);
    cfg_write(tfp_pkg::REG_GAIN_SPEED, s.gain_speed);
    cfg_write(tfp_pkg::REG_GAIN_BOOST, s.gain_boost);
    cfg_write(tfp_pkg::REG_BOOST_THR, 16'(s.boost_threshold));
    cfg_write(tfp_pkg::REG_DRIVE_LIMIT, 16'(s.drive_limit));
    cfg_write(tfp_pkg::REG_DEADBAND, 16'(s.deadband_offset));
    cfg_write(tfp_pkg::REG_TILT_OFFSET, s.tilt_offset);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : pwm_sink
    pwm_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pwm.size() == 0) begin
        errors++;
        $display("%0t: unexpected item duty=%0d reverse=%0b", $time,
                 out_tdata[12:0], out_tdata[13]);
      end else begin
        want = pending_pwm.pop_front();
        if (out_tdata[12:0] != want.duty) begin
          errors++;
          $display("%0t: duty expected %0d got %0d", $time, want.duty, out_tdata[12:0]);
        end
        if (out_tdata[13] != want.rev) begin
          errors++;
          $display("%0t: reverse expected %0b got %0b", $time, want.rev, out_tdata[13]);
        end
      end
    end
    if (sink_hold || (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct))
      out_tready <= 1'b0;
    else
      out_tready <= 1'b1;
  end

  initial begin : stimulus
    logic [15:0]        inv;
    logic [15:0]        a_fit;
    logic signed [15:0] g_fit;
    longint             s_next, r_next, t_next, thr_fit;
    int                 hits, tries;

    drive_regs = Presets[0];
    tilt_q16   = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (Probes[i])
      send_item(Probes[i].accel, Probes[i].gyro, Probes[i].wheel, Probes[i].typed,
                Probes[i].want);
    wait_idle();

    // small gain on tilt only: sums just below zero must truncate to zero
    apply_settings('{-16'sd1, 16'sd0, 16'sd0, 16'sd0, 15'h7FFF, 12'hFFF, 12'd100, 16'sd0});
    repeat (20)
      send_item(16'($urandom_range(100) - 50), 16'($urandom_range(40) - 20), pick_sample(),
                1'b0, '0);
    wait_idle();

    // boost band edge: pick accel so the new tilt is a whole integer, then put
    // the threshold on it or one below it
    apply_settings('{16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 15'd0, 12'hFFF, 12'd0, 16'sd0});
    inv = 16'd9175;
    repeat (4) inv = inv * (16'd2 - 16'd9175 * inv);
    hits = 0;
    for (tries = 0; tries < 400 && hits < 10; tries++) begin
      g_fit  = 16'($urandom_range(4000) - 2000);
      s_next = tilt_q16 + longint'(g_fit) * GyroQ16;
      r_next = (s_next * KeepQ16 + 32768) >>> 16;
      a_fit  = 16'(r_next) * inv;
      t_next = r_next - longint'($signed(a_fit)) * MixQ16;
      if (t_next < (longint'(1) <<< 31) && t_next > -(longint'(1) <<< 31)) begin
        thr_fit = ((t_next < 0) ? -t_next : t_next) >>> 16;
        if (hits % 2 == 1 && thr_fit != 0) thr_fit = thr_fit - 1;
        wait_idle();
        cfg_write(tfp_pkg::REG_BOOST_THR, 16'(thr_fit));
        cfg_valid <= 1'b0;
        send_item($signed(a_fit), g_fit, 16'sd0, 1'b0, '0);
        hits++;
      end else begin
        send_item((tilt_q16 > 0) ? 16'sh7FFF : 16'sh8000, 16'sd0, 16'sd0, 1'b0, '0);
      end
    end
    wait_idle();

    for (int k = 0; k < 8; k++) begin
      apply_settings((k < 4) ? Presets[k] : pick_settings());
      for (int mode = 0; mode < 4; mode++) begin
        case (mode)
          0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
          1: begin src_idle_pct = 80; sink_stall_pct = 0;  end
          2: begin src_idle_pct = 0;  sink_stall_pct = 80; end
          default: begin src_idle_pct = 27; sink_stall_pct = 27; end
        endcase
        send_random(32);
      end
      wait_idle();
    end

    // receiver holds off while items keep coming, so the input backs up
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    fork
      begin
        sink_hold <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        sink_hold <= 1'b0;
      end
      send_random(40);
    join

    in_tvalid <= 1'b0;
    while (pending_pwm.size() != 0) @(posedge clk);
    repeat (IdleGap) @(posedge clk);
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
src/tfp_pkg.sv
src/tfp_regs.sv
src/tfp_ctrl.sv
src/tfp_dpath.sv
src/tilt_filter_pid_pwm_boosted_unit.sv
test/testbench.sv
